// ===== sv/spsn_pkg.sv =====
// ----------------------------------------------------------------------------
// spsn_pkg
// Shared types and constants for the squared-norm point sorter.
// ----------------------------------------------------------------------------
package spsn_pkg;

    localparam int COORD_W = 16;
    localparam int KEY_W   = 32;

    typedef struct packed {
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
        logic                      set_end;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic signed [COORD_W-1:0] out_z;
        logic [KEY_W-1:0]          sq_norm;
        logic                      run_end;
        logic                      overflow;
    } t_out_item;

    // control shared by every cell of the chain
    typedef struct packed {
        logic insert;
        logic drain;
    } t_cell_ctl;

endpackage

// ===== sv/spsn_key_unit.sv =====
// ----------------------------------------------------------------------------
// spsn_key_unit
// Two-stage squared-norm pipeline: squares, then saturating sum.
// ----------------------------------------------------------------------------
module spsn_key_unit #(
    parameter int COORD_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  spsn_pkg::t_in_item        i_in,
    output logic                      o_valid,
    output logic                      o_last,
    output logic [spsn_pkg::KEY_W-1:0] o_key,
    output logic [3*COORD_BITS-1:0]   o_pt,
    output logic                      o_last_pending
);
    import spsn_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int SQ_W  = 2 * CB;
    localparam int SUM_W = (SQ_W + 2 > KEY_W + 1) ? SQ_W + 2 : KEY_W + 1;

    logic [CB-1:0]    w_c   [3];
    logic [CB-1:0]    w_mag [3];
    logic [SQ_W-1:0]  w_sq  [3];
    logic [SUM_W-1:0] w_sum;
    logic [KEY_W-1:0] w_key;

    logic [SQ_W-1:0]   r_s1_sq [3];
    logic [3*CB-1:0]   r_s1_pt;
    logic              r_s1_valid;
    logic              r_s1_last;
    logic [KEY_W-1:0]  r_s2_key;
    logic [3*CB-1:0]   r_s2_pt;
    logic              r_s2_valid;
    logic              r_s2_last;

    // fields are taken as raw bit patterns, then read as CB-bit two's complement
    assign w_c[0] = CB'($unsigned(i_in.coord_x));
    assign w_c[1] = CB'($unsigned(i_in.coord_y));
    assign w_c[2] = CB'($unsigned(i_in.coord_z));

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_mag[i] = w_c[i][CB-1] ? (~w_c[i] + CB'(1)) : w_c[i];
            w_sq[i]  = w_mag[i] * w_mag[i];
        end
    end

    assign w_sum = SUM_W'(r_s1_sq[0]) + SUM_W'(r_s1_sq[1]) + SUM_W'(r_s1_sq[2]);
    assign w_key = (|w_sum[SUM_W-1:KEY_W]) ? {KEY_W{1'b1}} : w_sum[KEY_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_last  <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s2_last  <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
            r_s1_last  <= i_valid & i_in.set_end;
            r_s2_valid <= r_s1_valid;
            r_s2_last  <= r_s1_valid & r_s1_last;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_s1_sq[i] <= w_sq[i];
        end
        r_s1_pt  <= {w_c[2], w_c[1], w_c[0]};
        r_s2_key <= w_key;
        r_s2_pt  <= r_s1_pt;
    end

    assign o_valid        = r_s2_valid;
    assign o_last         = r_s2_last;
    assign o_key          = r_s2_key;
    assign o_pt           = r_s2_pt;
    assign o_last_pending = (r_s1_valid & r_s1_last) | (r_s2_valid & r_s2_last);

endmodule

// ===== sv/spsn_cell.sv =====
// ----------------------------------------------------------------------------
// spsn_cell
// One slot of the sorted chain: keeps, takes the new point, or shifts.
// ----------------------------------------------------------------------------
module spsn_cell #(
    parameter int COORD_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  spsn_pkg::t_cell_ctl        i_ctl,
    input  logic [spsn_pkg::KEY_W-1:0] i_new_key,
    input  logic [3*COORD_BITS-1:0]    i_new_pt,
    input  logic                       i_prev_after,
    input  logic [spsn_pkg::KEY_W-1:0] i_prev_key,
    input  logic [3*COORD_BITS-1:0]    i_prev_pt,
    input  logic                       i_prev_valid,
    input  logic [spsn_pkg::KEY_W-1:0] i_next_key,
    input  logic [3*COORD_BITS-1:0]    i_next_pt,
    input  logic                       i_next_valid,
    output logic [spsn_pkg::KEY_W-1:0] o_key,
    output logic [3*COORD_BITS-1:0]    o_pt,
    output logic                       o_valid,
    output logic                       o_after
);
    import spsn_pkg::*;

    logic [KEY_W-1:0]        r_key, n_key;
    logic [3*COORD_BITS-1:0] r_pt,  n_pt;
    logic                    r_valid, n_valid;
    logic                    w_after;

    // new point lands behind this cell when the stored key is not above it
    assign w_after = r_valid && (r_key <= i_new_key);

    always_comb begin
        n_key   = r_key;
        n_pt    = r_pt;
        n_valid = r_valid;
        if (i_ctl.drain) begin
            n_key   = i_next_key;
            n_pt    = i_next_pt;
            n_valid = i_next_valid;
        end else if (i_ctl.insert && !w_after) begin
            if (i_prev_after) begin
                n_key   = i_new_key;
                n_pt    = i_new_pt;
                n_valid = 1'b1;
            end else begin
                n_key   = i_prev_key;
                n_pt    = i_prev_pt;
                n_valid = i_prev_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_pt  <= n_pt;
    end

    assign o_key   = r_key;
    assign o_pt    = r_pt;
    assign o_valid = r_valid;
    assign o_after = w_after;

endmodule

// ===== sv/sort_points_by_squared_norm_core.sv =====
// ----------------------------------------------------------------------------
// sort_points_by_squared_norm_core
// Insertion-sorting chain of cells ordered by exact squared norm.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+--------------------------
//  input   | start / busy       | i_in  (t_in_item)
//  output  | o_out_valid strobe | o_out (t_out_item)
//
//  points without set_end are taken one per cycle while busy is low; the key
//  pipeline is two stages deep and the chain inserts a point as it leaves
//  the second stage, unless the chain is full. a set_end transaction holds
//  busy through the key pipeline and then while the chain shifts its stored
//  points toward cell 0, one result per cycle, each result showing in the
//  cycle after its shift.
//  synchronous reset empties every cell; results cannot be stalled.
// ----------------------------------------------------------------------------
module sort_points_by_squared_norm_core #(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  spsn_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    output spsn_pkg::t_out_item o_out
);
    import spsn_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int PT_W  = 3 * CB;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_POINTS);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    logic             w_accept;
    logic             w_s2_valid;
    logic             w_s2_last;
    logic [KEY_W-1:0] w_s2_key;
    logic [PT_W-1:0]  w_s2_pt;
    logic             w_last_pending;
    logic             w_full;
    logic             w_insert;
    t_cell_ctl        w_ctl;

    // index 0 and MAX_POINTS+1 are chain ends, cell g sits at index g+1
    logic [KEY_W-1:0] w_key   [0:MAX_POINTS+1];
    logic [PT_W-1:0]  w_pt    [0:MAX_POINTS+1];
    logic             w_valid [0:MAX_POINTS+1];
    logic             w_after [0:MAX_POINTS];

    logic [CNT_W-1:0] r_count;
    logic             r_dropped;
    logic             r_drain;
    logic             r_out_valid;
    t_out_item        r_out;

    logic signed [CB-1:0] w_hx, w_hy, w_hz;

    assign w_accept = start && !busy;
    assign busy     = w_last_pending | r_drain;

    spsn_key_unit #(
        .COORD_BITS (COORD_BITS)
    ) u_key (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_accept),
        .i_in           (i_in),
        .o_valid        (w_s2_valid),
        .o_last         (w_s2_last),
        .o_key          (w_s2_key),
        .o_pt           (w_s2_pt),
        .o_last_pending (w_last_pending)
    );

    assign w_full       = (r_count == CNT_FULL);
    assign w_insert     = w_s2_valid && !w_full;
    assign w_ctl.insert = w_insert;
    assign w_ctl.drain  = r_drain;

    assign w_key[0]              = '0;
    assign w_pt[0]               = '0;
    assign w_valid[0]            = 1'b0;
    assign w_after[0]            = 1'b1;
    assign w_key[MAX_POINTS+1]   = '0;
    assign w_pt[MAX_POINTS+1]    = '0;
    assign w_valid[MAX_POINTS+1] = 1'b0;

    for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
        spsn_cell #(
            .COORD_BITS (COORD_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_new_key    (w_s2_key),
            .i_new_pt     (w_s2_pt),
            .i_prev_after (w_after[g]),
            .i_prev_key   (w_key[g]),
            .i_prev_pt    (w_pt[g]),
            .i_prev_valid (w_valid[g]),
            .i_next_key   (w_key[g+2]),
            .i_next_pt    (w_pt[g+2]),
            .i_next_valid (w_valid[g+2]),
            .o_key        (w_key[g+1]),
            .o_pt         (w_pt[g+1]),
            .o_valid      (w_valid[g+1]),
            .o_after      (w_after[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_dropped   <= 1'b0;
            r_drain     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_drain;
            if (r_drain) begin
                if (r_count == CNT_ONE) begin
                    r_drain   <= 1'b0;
                    r_dropped <= 1'b0;
                end
                r_count <= r_count - CNT_ONE;
            end else begin
                if (w_insert) begin
                    r_count <= r_count + CNT_ONE;
                end
                if (w_s2_valid && w_full) begin
                    r_dropped <= 1'b1;
                end
                if (w_s2_valid && w_s2_last) begin
                    r_drain <= 1'b1;
                end
            end
        end
    end

    // head cell coordinates, narrowed or sign-extended to the field width
    assign w_hx = w_pt[1][CB-1:0];
    assign w_hy = w_pt[1][2*CB-1:CB];
    assign w_hz = w_pt[1][3*CB-1:2*CB];

    always_ff @(posedge i_clk) begin
        r_out.out_x    <= COORD_W'(w_hx);
        r_out.out_y    <= COORD_W'(w_hy);
        r_out.out_z    <= COORD_W'(w_hz);
        r_out.sq_norm  <= w_key[1];
        r_out.run_end  <= (r_count == CNT_ONE);
        r_out.overflow <= r_dropped;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== sv/spsn_checker.sv =====
// ----------------------------------------------------------------------------
// spsn_checker
// Port-level checks on the sorter's result runs, bound to the top level.
// ----------------------------------------------------------------------------
module spsn_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input spsn_pkg::t_in_item  i_in,
    input logic                o_out_valid,
    input spsn_pkg::t_out_item o_out
);
    import spsn_pkg::*;

    // a run is contiguous: no gap before its last result
    a_run_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.run_end |=> o_out_valid)
        else $error("result run broke before its last transaction");

    // keys never decrease inside a run
    a_run_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && $past(o_out_valid) && !$past(o_out.run_end)
        |-> o_out.sq_norm >= $past(o_out.sq_norm))
        else $error("result keys out of order");

    // overflow is one value for the whole run
    a_overflow_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && $past(o_out_valid) && !$past(o_out.run_end)
        |-> $stable(o_out.overflow))
        else $error("overflow changed inside a run");

    // a closing point locks the input: busy is high right after it is accepted
    a_end_locks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_in.set_end |=> busy)
        else $error("input open right after a set_end transaction");

    // no result follows directly on the last result of a run
    a_run_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.run_end |=> !o_out_valid)
        else $error("result directly after the end of a run");

endmodule

bind sort_points_by_squared_norm_core spsn_checker u_spsn_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .o_out       (o_out)
);
